FILE: rtl/ptlru_pkg.sv
// Shared codes and types for the page table with LRU / FIFO replacement.
`default_nettype none

package ptlru_pkg;

   // page and frame counts
   localparam int NUM_PAGES  = 64;
   localparam int NUM_FRAMES = 16;

   // page status codes held in the page memory
   localparam logic [1:0] ST_UNUSED = 2'd0;
   localparam logic [1:0] ST_MEM    = 2'd1;
   localparam logic [1:0] ST_DISK   = 2'd2;

   // register index decoded from paddr[2]
   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_FRAMES = 1'b1;

   // replacement policy codes
   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   // per-field write enables of one page record
   typedef struct packed {
      logic status;
      logic dirty;
      logic frame;
      logic next;
      logic prev;
   } wmask_type;

endpackage

`default_nettype wire

FILE: rtl/ptlru_req_if.sv
// Request channel: one page reference per word.
`default_nettype none

interface ptlru_req_if #(
   parameter int PAGE_NUM_W = 7
);
   logic                  valid;
   logic                  ready;
   logic [PAGE_NUM_W-1:0] page_number;
   logic                  access_write;

   modport source (output valid, output page_number, output access_write, input ready);
   modport sink   (input valid, input page_number, input access_write, output ready);
endinterface

`default_nettype wire

FILE: rtl/ptlru_rsp_if.sv
// Response channel: frame and fault / eviction flags per word.
`default_nettype none

interface ptlru_rsp_if #(
   parameter int FRAME_W  = 4,
   parameter int VICTIM_W = 6
);
   logic                valid;
   logic                ready;
   logic [FRAME_W-1:0]  frame_number;
   logic                was_hit;
   logic                evicted;
   logic [VICTIM_W-1:0] evict_page;
   logic                write_back;
   logic                bad_page;

   modport source (output valid, output frame_number, output was_hit, output evicted,
                   output evict_page, output write_back, output bad_page, input ready);
   modport sink   (input valid, input frame_number, input was_hit, input evicted,
                   input evict_page, input write_back, input bad_page, output ready);
endinterface

`default_nettype wire

FILE: rtl/page_table_lru_fifo_replacement.sv
// Page table with LRU / FIFO replacement: sequencer over one page-record memory.
//
//  channel | dir | handshake             | word
//  req_ch  | in  | valid / ready         | page_number, access_write
//  rsp_ch  | out | valid / ready         | frame_number, was_hit, evicted, evict_page,
//          |     |                       | write_back, bad_page
//  apb     | in  | psel, penable, pready | paddr, pwdata, pwrite / prdata
//
// One reference at a time. A bad page goes straight to the result; a hit without a move
// sets the dirty bit on a write and finishes; an LRU hit that moves the page unlinks it
// and relinks it at the tail; a fault takes a free frame or evicts the head page. The
// single-port page memory (one field-masked write per cycle, registered read) sets the
// pace: each list link touched costs its own memory access. Synchronous reset clears
// control state and all entry valid bits. A held result stalls the sequencer at its last
// step; the next word is taken at the edge after the result is loaded into the output register.
`default_nettype none

module page_table_lru_fifo_replacement
   import ptlru_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   ptlru_req_if.sink        req_ch,
   ptlru_rsp_if.source      rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   localparam int PW    = $clog2(NUM_PAGES);
   localparam int LW    = PW + 1;
   localparam int PNW   = PW + 1;
   localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int FIU_W = $clog2(NUM_FRAMES + 1);
   localparam logic [LW-1:0]    NIL        = LW'(NUM_PAGES);
   localparam logic [FIU_W-1:0] FRAME_MAX  = FIU_W'(NUM_FRAMES);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_READ     = 4'd1;
   localparam logic [3:0] S_UNLINK1  = 4'd2;
   localparam logic [3:0] S_UNLINK2  = 4'd3;
   localparam logic [3:0] S_LINKTAIL = 4'd4;
   localparam logic [3:0] S_WRPG     = 4'd5;
   localparam logic [3:0] S_RDVIC    = 4'd6;
   localparam logic [3:0] S_VICNEXT  = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   typedef struct packed {
      logic [1:0]    status;
      logic          dirty;
      logic [FW-1:0] frame;
      logic [LW-1:0] next;
      logic [LW-1:0] prev;
   } rec_type;

   // page record memory and its entry valid bits
   rec_type             mem_ram [NUM_PAGES];
   logic [NUM_PAGES-1:0] vld_ff;
   rec_type             mem_q_ff;
   logic                mem_qv_ff;
   rec_type             rd_rec;
   logic                rd_en;
   logic [PW-1:0]       rd_addr;
   wmask_type           we;
   logic [PW-1:0]       wa;
   rec_type             wd;

   // control and scratch registers
   logic [3:0]       state_ff, state_in;
   logic [PW-1:0]    pg_ff, pg_in;
   logic             wr_ff, wr_in;
   rec_type          rec_ff, rec_in;
   logic             hit_ff, hit_in;
   logic             ev_ff, ev_in;
   logic [PW-1:0]    victim_ff, victim_in;
   logic             wb_ff, wb_in;
   logic [FW-1:0]    fno_ff, fno_in;
   logic             bad_ff, bad_in;
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic             empty_ff, empty_in;
   logic [FIU_W-1:0] given_ff, given_in;
   logic             policy_ff;
   logic [FIU_W-1:0] fiu_ff;
   logic [FIU_W-1:0] limit;

   // output register
   logic             rsp_valid_ff;
   logic [FW-1:0]    rsp_frame_ff;
   logic             rsp_hit_ff;
   logic             rsp_ev_ff;
   logic [PW-1:0]    rsp_victim_ff;
   logic             rsp_wb_ff;
   logic             rsp_bad_ff;
   logic             rsp_load;

   logic             req_take;
   logic             csr_wr;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rd_rec       = mem_qv_ff ? mem_q_ff : '0;
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // frames in use, clamped to 1..NUM_FRAMES
   always_comb begin
      if (fiu_ff == '0) begin
         limit = FIU_W'(1);
      end else if (fiu_ff > FRAME_MAX) begin
         limit = FRAME_MAX;
      end else begin
         limit = fiu_ff;
      end
   end

   // sequencer: one memory access per cycle
   always_comb begin
      state_in  = state_ff;
      pg_in     = pg_ff;
      wr_in     = wr_ff;
      rec_in    = rec_ff;
      hit_in    = hit_ff;
      ev_in     = ev_ff;
      victim_in = victim_ff;
      wb_in     = wb_ff;
      fno_in    = fno_ff;
      bad_in    = bad_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      given_in  = given_ff;
      rd_en     = 1'b0;
      rd_addr   = pg_ff;
      we        = '0;
      wa        = pg_ff;
      wd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pg_in     = req_ch.page_number[PW-1:0];
               wr_in     = req_ch.access_write;
               hit_in    = 1'b0;
               ev_in     = 1'b0;
               victim_in = '0;
               wb_in     = 1'b0;
               fno_in    = '0;
               if (req_ch.page_number >= PNW'(NUM_PAGES)) begin
                  bad_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  bad_in   = 1'b0;
                  rd_en    = 1'b1;
                  rd_addr  = req_ch.page_number[PW-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            rec_in = rd_rec;
            if (rd_rec.status == ST_MEM) begin
               hit_in = 1'b1;
               fno_in = rd_rec.frame;
               if (policy_ff == POLICY_LRU && rd_rec.next < NIL) begin
                  state_in = S_UNLINK1;
               end else begin
                  we.dirty = wr_ff;
                  wd.dirty = 1'b1;
                  state_in = S_DONE;
               end
            end else if (given_ff < limit) begin
               // hand out the next free frame
               fno_in   = given_ff[FW-1:0];
               given_in = given_ff + FIU_W'(1);
               state_in = empty_ff ? S_WRPG : S_LINKTAIL;
            end else if (!empty_ff) begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = S_RDVIC;
            end else begin
               fno_in   = '0;
               state_in = S_WRPG;
            end
         end
         S_UNLINK1: begin
            if (rec_ff.prev >= NIL) begin
               // page is at the head: successor becomes head
               head_in  = rec_ff.next[PW-1:0];
               wa       = rec_ff.next[PW-1:0];
               we.prev  = 1'b1;
               wd.prev  = NIL;
               state_in = S_LINKTAIL;
            end else begin
               wa       = rec_ff.prev[PW-1:0];
               we.next  = 1'b1;
               wd.next  = rec_ff.next;
               state_in = S_UNLINK2;
            end
         end
         S_UNLINK2: begin
            wa       = rec_ff.next[PW-1:0];
            we.prev  = 1'b1;
            wd.prev  = rec_ff.prev;
            state_in = S_LINKTAIL;
         end
         S_LINKTAIL: begin
            wa       = tail_ff;
            we.next  = 1'b1;
            wd.next  = LW'(pg_ff);
            state_in = S_WRPG;
         end
         S_WRPG: begin
            wa      = pg_ff;
            tail_in = pg_ff;
            if (hit_ff) begin
               we.prev  = 1'b1;
               we.next  = 1'b1;
               we.dirty = wr_ff;
               wd.prev  = LW'(tail_ff);
               wd.next  = NIL;
               wd.dirty = 1'b1;
            end else begin
               we        = '1;
               wd.status = ST_MEM;
               wd.dirty  = wr_ff;
               wd.frame  = fno_ff;
               wd.next   = NIL;
               wd.prev   = empty_ff ? NIL : LW'(tail_ff);
               if (empty_ff) begin
                  head_in  = pg_ff;
                  empty_in = 1'b0;
               end
            end
            state_in = S_DONE;
         end
         S_RDVIC: begin
            // evict the head page
            ev_in     = 1'b1;
            victim_in = head_ff;
            wb_in     = rd_rec.dirty;
            fno_in    = rd_rec.frame;
            wa        = head_ff;
            we.status = 1'b1;
            we.dirty  = 1'b1;
            wd.status = ST_DISK;
            wd.dirty  = 1'b0;
            if (rd_rec.next >= NIL) begin
               empty_in = 1'b1;
               state_in = S_WRPG;
            end else begin
               head_in  = rd_rec.next[PW-1:0];
               state_in = S_VICNEXT;
            end
         end
         S_VICNEXT: begin
            wa       = head_ff;
            we.prev  = 1'b1;
            wd.prev  = NIL;
            state_in = S_LINKTAIL;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // page memory: field-masked write, registered read
   always_ff @(posedge clock) begin
      if (we.status) mem_ram[wa].status <= wd.status;
      if (we.dirty)  mem_ram[wa].dirty  <= wd.dirty;
      if (we.frame)  mem_ram[wa].frame  <= wd.frame;
      if (we.next)   mem_ram[wa].next   <= wd.next;
      if (we.prev)   mem_ram[wa].prev   <= wd.prev;
      if (rd_en) begin
         mem_q_ff  <= mem_ram[rd_addr];
         mem_qv_ff <= vld_ff[rd_addr];
      end
   end

   // entry valid bits: an unwritten entry reads as unused and clean
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (|we) begin
         vld_ff[wa] <= 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         given_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         given_ff <= given_in;
      end
   end

   // scratch for the item in flight
   always_ff @(posedge clock) begin
      pg_ff     <= pg_in;
      wr_ff     <= wr_in;
      rec_ff    <= rec_in;
      hit_ff    <= hit_in;
      ev_ff     <= ev_in;
      victim_ff <= victim_in;
      wb_ff     <= wb_in;
      fno_ff    <= fno_in;
      bad_ff    <= bad_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_frame_ff  <= fno_ff;
         rsp_hit_ff    <= hit_ff;
         rsp_ev_ff     <= ev_ff;
         rsp_victim_ff <= victim_ff;
         rsp_wb_ff     <= wb_ff;
         rsp_bad_ff    <= bad_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_number = rsp_frame_ff;
   assign rsp_ch.was_hit      = rsp_hit_ff;
   assign rsp_ch.evicted      = rsp_ev_ff;
   assign rsp_ch.evict_page   = rsp_victim_ff;
   assign rsp_ch.write_back   = rsp_wb_ff;
   assign rsp_ch.bad_page     = rsp_bad_ff;

   // register port
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_LRU;
         fiu_ff    <= FRAME_MAX;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_POLICY: policy_ff <= pwdata[0];
            REG_FRAMES: fiu_ff    <= pwdata[FIU_W-1:0];
            default:    policy_ff <= policy_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_POLICY: prdata = 32'(policy_ff);
         REG_FRAMES: prdata = 32'(fiu_ff);
         default:    prdata = '0;
      endcase
   end

   // checks
   a_bad_to_done: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.page_number >= PNW'(NUM_PAGES)) |=> (state_ff == S_DONE))
      else $error("bad page did not go straight to result");

   a_list_has_frame: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (given_ff != '0))
      else $error("list holds pages but no frame was handed out");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && (|we)))
      else $error("read and write of page memory in the same cycle");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.was_hit && rsp_ch.evicted))
      else $error("result flags both hit and eviction");

endmodule

`default_nettype wire
